// ===== hw/rtl/qte_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package qte_pkg;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int QUAT_BITS_DEF = 16;
	localparam int ANG_FRAC = 24;
	// sums carry 30 fraction bits; worst case |sum| < 2^33, keep margin
	localparam int VEC_W = 36;
	localparam int ANG_W = 28;
	localparam logic signed [ANG_W-1:0] HALF_PI_A = 28'sd26353589;
	localparam logic signed [15:0] ROLL_LIM = 16'sd25736;
	localparam logic signed [14:0] PITCH_LIM = 15'sd12868;
	localparam int SQ_W = 62;

	function automatic logic signed [ANG_W-1:0] atan_step(input int i);
		logic signed [ANG_W-1:0] r;
		begin
			unique case (i)
				0: r = 28'sd13176795;
				1: r = 28'sd7778716;
				2: r = 28'sd4110060;
				3: r = 28'sd2086331;
				4: r = 28'sd1047214;
				5: r = 28'sd524117;
				6: r = 28'sd262123;
				7: r = 28'sd131069;
				default: r = (i <= ANG_FRAC) ? ANG_W'(1) <<< (ANG_FRAC - i) : '0;
			endcase
			return r;
		end
	endfunction

	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ANG_W-1:0] z;
	} vec_t;
endpackage
`default_nettype wire

// ===== hw/rtl/qte_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface qte_in_if #(parameter int QUAT_BITS = 16);
	logic valid;
	logic ready;
	logic signed [QUAT_BITS-1:0] quat_x;
	logic signed [QUAT_BITS-1:0] quat_y;
	logic signed [QUAT_BITS-1:0] quat_z;
	logic signed [QUAT_BITS-1:0] quat_w;
	logic signed [15:0] rate_about_x;
	logic signed [15:0] rate_about_y;
	modport source (output valid, quat_x, quat_y, quat_z, quat_w, rate_about_x,
		rate_about_y, input ready);
	modport sink (input valid, quat_x, quat_y, quat_z, quat_w, rate_about_x,
		rate_about_y, output ready);
endinterface

interface qte_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] frame_roll;
	logic signed [14:0] frame_pitch;
	logic signed [14:0] control_roll;
	logic signed [15:0] control_pitch;
	logic signed [15:0] roll_rate;
	logic signed [15:0] pitch_rate;
	modport source (output valid, frame_roll, frame_pitch, control_roll, control_pitch,
		roll_rate, pitch_rate, input ready);
	modport sink (input valid, frame_roll, frame_pitch, control_roll, control_pitch,
		roll_rate, pitch_rate, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/qte_cordic_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One vectoring micro-rotation, registered. Stalls with the pipeline enable.
module qte_cordic_cell #(
	parameter int STAGE = 0
) (
	input wire logic clk,
	input wire logic en,
	input wire qte_pkg::vec_t d,
	output qte_pkg::vec_t q
);
	import qte_pkg::*;
	vec_t n;
	always_comb begin
		if (d.y > 0) begin
			n.x = d.x + (d.y >>> STAGE);
			n.y = d.y - (d.x >>> STAGE);
			n.z = d.z + atan_step(STAGE);
		end else begin
			n.x = d.x - (d.y >>> STAGE);
			n.y = d.y + (d.x >>> STAGE);
			n.z = d.z - atan_step(STAGE);
		end
	end
	always_ff @(posedge clk) begin
		if (en) q <= n;
	end
endmodule
`default_nettype wire

// ===== hw/rtl/qte_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One step of the digit-by-digit square root: resolves one result bit.
// rem/res follow the classic bit-pair method; BIT_POS is the pair index.
module qte_sqrt_cell #(
	parameter int BIT_POS = 0
) (
	input wire logic clk,
	input wire logic en,
	input wire logic [qte_pkg::SQ_W-1:0] rem_d,
	input wire logic [qte_pkg::SQ_W-1:0] res_d,
	output logic [qte_pkg::SQ_W-1:0] rem_q,
	output logic [qte_pkg::SQ_W-1:0] res_q
);
	import qte_pkg::*;
	localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * BIT_POS);
	logic [SQ_W-1:0] trial;
	always_comb trial = res_d + BIT;
	always_ff @(posedge clk) begin
		if (en) begin
			if (rem_d >= trial) begin
				rem_q <= rem_d - trial;
				res_q <= (res_d >> 1) + BIT;
			end else begin
				rem_q <= rem_d;
				res_q <= res_d >> 1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/quaternion_tilt_extractor_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Quaternion tilt extractor.
// in  (sink):   one IMU sample per item: quaternion x,y,z,w (Q1.QUAT_BITS-1)
//               and the body rates about x and y.
// out (source): raw roll/pitch and control-frame roll/pitch (axes swapped),
//               radians Q3.13 roll and Q2.13 pitch, plus the swapped rates.
// Pipeline: 2 product stages, 31 square-root cells for the pitch cosine,
// 1 pre-rotation stage, CORDIC_STAGES CORDIC cells (roll and pitch rows run
// side by side), 1 rounding stage. Throughput is one item per cycle
// while no stall holds the row; every stage is a cell in one row.
// The whole row advances together: ready is low only when the output
// register holds an item the receiver has not taken, so a stall freezes
// every cell and nothing is lost. Reset clears the valid bits; data
// registers are not reset.
module quaternion_tilt_extractor_top #(
	parameter int CORDIC_STAGES = qte_pkg::CORDIC_STAGES_DEF,
	parameter int QUAT_BITS = qte_pkg::QUAT_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	qte_in_if.sink in_ch,
	qte_out_if.source out_ch
);
	import qte_pkg::*;
	localparam int SQ_STEPS = 31;
	localparam int DEPTH = 2 + SQ_STEPS + 1 + CORDIC_STAGES + 1;
	localparam int PW = 2 * QUAT_BITS;
	localparam int TWOF = 2 * (QUAT_BITS - 1);

	logic en;
	logic [DEPTH-1:0] vld_q;
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[DEPTH-2:0], in_ch.valid};
	end
	assign out_ch.valid = vld_q[DEPTH-1];

	// rates travel alongside
	logic [31:0] rate_q [DEPTH];
	always_ff @(posedge clk) begin
		if (en) begin
			rate_q[0] <= {in_ch.rate_about_y, in_ch.rate_about_x};
			for (int i = 1; i < DEPTH; i++) rate_q[i] <= rate_q[i-1];
		end
	end

	// stage 1: products
	logic signed [PW-1:0] p_wx_s1, p_yz_s1, p_xx_s1, p_yy_s1, p_wy_s1, p_zx_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			p_wx_s1 <= in_ch.quat_w * in_ch.quat_x;
			p_yz_s1 <= in_ch.quat_y * in_ch.quat_z;
			p_xx_s1 <= in_ch.quat_x * in_ch.quat_x;
			p_yy_s1 <= in_ch.quat_y * in_ch.quat_y;
			p_wy_s1 <= in_ch.quat_w * in_ch.quat_y;
			p_zx_s1 <= in_ch.quat_z * in_ch.quat_x;
		end
	end
	function automatic logic signed [VEC_W-1:0] to30(input logic signed [PW-1:0] p);
		logic signed [PW+VEC_W-1:0] e;
		begin
			e = (PW+VEC_W)'(p);
			if (TWOF >= 30) return VEC_W'(e >>> (TWOF - 30));
			return VEC_W'(e <<< (30 - TWOF));
		end
	endfunction
	// stage 2: sums
	logic signed [VEC_W-1:0] sinr_s2, cosr_s2, sinp_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			sinr_s2 <= (to30(p_wx_s1) + to30(p_yz_s1)) <<< 1;
			cosr_s2 <= (VEC_W'(1) <<< 30) - ((to30(p_xx_s1) + to30(p_yy_s1)) <<< 1);
			sinp_s2 <= (to30(p_wy_s1) - to30(p_zx_s1)) <<< 1;
		end
	end
	// pitch saturation and root operand
	logic psat_pos, psat_neg;
	logic [SQ_W-1:0] rad;
	logic signed [30:0] sp_lo;
	logic signed [61:0] s2;
	assign psat_pos = sinp_s2 >= (VEC_W'(1) <<< 30);
	assign psat_neg = sinp_s2 <= -(VEC_W'(1) <<< 30);
	// square only matters when |sinp| < 1.0, where 31 bits hold it
	assign sp_lo = sinp_s2[30:0];
	assign s2 = sp_lo * sp_lo;
	assign rad = (psat_pos || psat_neg) ? '0 : SQ_W'((64'd1 << 60) - 64'(s2));

	// square-root cell row; roll and sinp delayed alongside
	logic [SQ_W-1:0] rem_c [SQ_STEPS+1];
	logic [SQ_W-1:0] res_c [SQ_STEPS+1];
	logic signed [VEC_W-1:0] sr_d [SQ_STEPS+1];
	logic signed [VEC_W-1:0] cr_d [SQ_STEPS+1];
	logic signed [VEC_W-1:0] sp_d [SQ_STEPS+1];
	logic [1:0] sat_d [SQ_STEPS+1];
	assign rem_c[0] = rad;
	assign res_c[0] = '0;
	assign sr_d[0] = sinr_s2;
	assign cr_d[0] = cosr_s2;
	assign sp_d[0] = sinp_s2;
	assign sat_d[0] = {psat_pos, psat_neg};
	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
		qte_sqrt_cell #(.BIT_POS(SQ_STEPS - 1 - g)) u_cell (
			.clk(clk), .en(en), .rem_d(rem_c[g]), .res_d(res_c[g]),
			.rem_q(rem_c[g+1]), .res_q(res_c[g+1]));
		always_ff @(posedge clk) begin
			if (en) begin
				sr_d[g+1] <= sr_d[g];
				cr_d[g+1] <= cr_d[g];
				sp_d[g+1] <= sp_d[g];
				sat_d[g+1] <= sat_d[g];
			end
		end
	end

	// pre-rotation into the right half plane
	function automatic vec_t prerot(input logic signed [VEC_W-1:0] y,
		input logic signed [VEC_W-1:0] x);
		vec_t v;
		begin
			v.x = x; v.y = y; v.z = '0;
			if (x < 0) begin
				if (y >= 0) begin
					v.x = y; v.y = -x; v.z = HALF_PI_A;
				end else begin
					v.x = -y; v.y = x; v.z = -HALF_PI_A;
				end
			end
			return v;
		end
	endfunction
	vec_t rc [CORDIC_STAGES+1];
	vec_t pc [CORDIC_STAGES+1];
	logic rzero_q [CORDIC_STAGES+1];
	logic [1:0] psat_q [CORDIC_STAGES+1];
	always_ff @(posedge clk) begin
		if (en) begin
			rc[0] <= prerot(sr_d[SQ_STEPS], cr_d[SQ_STEPS]);
			pc[0] <= prerot(sp_d[SQ_STEPS], VEC_W'(res_c[SQ_STEPS]));
			rzero_q[0] <= (sr_d[SQ_STEPS] == 0) && (cr_d[SQ_STEPS] == 0);
			psat_q[0] <= sat_d[SQ_STEPS];
		end
	end
	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cor
		qte_cordic_cell #(.STAGE(g)) u_roll (.clk(clk), .en(en), .d(rc[g]), .q(rc[g+1]));
		qte_cordic_cell #(.STAGE(g)) u_pitch (.clk(clk), .en(en), .d(pc[g]), .q(pc[g+1]));
		always_ff @(posedge clk) begin
			if (en) begin
				rzero_q[g+1] <= rzero_q[g];
				psat_q[g+1] <= psat_q[g];
			end
		end
	end

	// rounding to Q3.13 (roll) and Q2.13 (pitch) and clamp
	logic signed [ANG_W-1:0] ra, pa, rr, pr;
	logic signed [15:0] roll_o;
	logic signed [14:0] pitch_o;
	always_comb begin
		ra = rzero_q[CORDIC_STAGES] ? '0 : rc[CORDIC_STAGES].z;
		priority if (psat_q[CORDIC_STAGES][1]) pa = HALF_PI_A;
		else if (psat_q[CORDIC_STAGES][0]) pa = -HALF_PI_A;
		else pa = pc[CORDIC_STAGES].z;
		rr = (ra + ANG_W'(1024)) >>> 11;
		pr = (pa + ANG_W'(1024)) >>> 11;
		if (rr > ANG_W'(ROLL_LIM)) roll_o = ROLL_LIM;
		else if (rr < -ANG_W'(ROLL_LIM)) roll_o = -ROLL_LIM;
		else roll_o = 16'(rr);
		if (pr > ANG_W'(PITCH_LIM)) pitch_o = PITCH_LIM;
		else if (pr < -ANG_W'(PITCH_LIM)) pitch_o = -PITCH_LIM;
		else pitch_o = 15'(pr);
	end
	logic signed [15:0] roll_s3;
	logic signed [14:0] pitch_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			roll_s3 <= roll_o;
			pitch_s3 <= pitch_o;
		end
	end
	assign out_ch.frame_roll = roll_s3;
	assign out_ch.control_pitch = roll_s3;
	assign out_ch.frame_pitch = pitch_s3;
	assign out_ch.control_roll = pitch_s3;
	assign out_ch.roll_rate = rate_q[DEPTH-1][31:16];
	assign out_ch.pitch_rate = rate_q[DEPTH-1][15:0];

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(roll_s3))
		else $error("result changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ch.valid |-> in_ch.ready) else $error("ready low with empty output");
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> pitch_s3 <= PITCH_LIM && pitch_s3 >= -PITCH_LIM)
		else $error("pitch out of range");
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import qte_pkg::*;

	// one IMU sample as offered on the input channel
	typedef struct packed {
		logic signed [15:0] qx;
		logic signed [15:0] qy;
		logic signed [15:0] qz;
		logic signed [15:0] qw;
		logic signed [15:0] wx;
		logic signed [15:0] wy;
	} sample_t;

	// expected tilt result for one sample
	typedef struct packed {
		logic signed [15:0] frame_roll;
		logic signed [14:0] frame_pitch;
		logic signed [14:0] control_roll;
		logic signed [15:0] control_pitch;
		logic signed [15:0] roll_rate;
		logic signed [15:0] pitch_rate;
	} tilt_t;

	localparam int LATENCY = CORDIC_STAGES_DEF + 35;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	qte_in_if #(.QUAT_BITS(16)) in_ch();
	qte_out_if out_ch();

	quaternion_tilt_extractor_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #1 clk = ~clk;

	sample_t pending_samples[$];
	tilt_t expected_tilts[$];
	int errors = 0;
	bit stim_done = 1'b0;
	// knobs the stimulus process uses to shape pressure
	bit send_idle_en = 1'b0;
	bit send_hold = 1'b0;
	bit recv_idle_en = 1'b0;
	bit recv_hold_go = 1'b0;
	bit recv_hold = 1'b0;
	// input handshake seen at the last rising edge
	bit in_taken = 1'b0;

	// --- fixed-point tilt math -------------------------------------------
	// products are brought to 30 fraction bits: Q1.15 * Q1.15 is already Q2.30
	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint vector_angle(longint y, longint x);
		longint z, dx, dy, t;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = HALF_PI_A;
			end else begin
				x = -y;
				y = t;
				z = -HALF_PI_A;
			end
		end
		for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx;
				y -= dy;
				z += longint'(atan_step(i));
			end else begin
				x -= dx;
				y += dy;
				z -= longint'(atan_step(i));
			end
		end
		return z;
	endfunction

	function automatic longint round_q13(longint z, longint lim);
		longint q;
		q = (z + 1024) >>> 11;
		if (q > lim) q = lim;
		if (q < -lim) q = -lim;
		return q;
	endfunction

	function automatic tilt_t predict_tilt(sample_t s);
		longint qx, qy, qz, qw, sinr, cosr, sinp, roll_a, pitch_a, rq, pq;
		longint one30;
		tilt_t r;
		qx = s.qx;
		qy = s.qy;
		qz = s.qz;
		qw = s.qw;
		one30 = 64'sd1 << 30;
		sinr = 2 * (qw * qx + qy * qz);
		cosr = one30 - 2 * (qx * qx + qy * qy);
		sinp = 2 * (qw * qy - qz * qx);
		roll_a = vector_angle(sinr, cosr);
		if (sinp >= one30) pitch_a = HALF_PI_A;
		else if (sinp <= -one30) pitch_a = -HALF_PI_A;
		else pitch_a = vector_angle(sinp,
			longint'(int_sqrt((64'd1 << 60) - longint'(sinp * sinp))));
		rq = round_q13(roll_a, ROLL_LIM);
		pq = round_q13(pitch_a, PITCH_LIM);
		r.frame_roll = rq[15:0];
		r.frame_pitch = pq[14:0];
		r.control_roll = pq[14:0];
		r.control_pitch = rq[15:0];
		r.roll_rate = s.wy;
		r.pitch_rate = s.wx;
		return r;
	endfunction

	// --- driver: sends pending samples, changes inputs on the falling edge ---
	initial begin
		in_ch.valid = 1'b0;
		{in_ch.quat_x, in_ch.quat_y, in_ch.quat_z, in_ch.quat_w} = '0;
		{in_ch.rate_about_x, in_ch.rate_about_y} = '0;
		out_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		in_taken <= in_ch.valid && in_ch.ready;
	end

	// receiver hold-off, counted in its own process
	initial begin
		wait (recv_hold_go);
		@(posedge clk);
		recv_hold = 1'b1;
		repeat (3 * LATENCY) @(posedge clk);
		recv_hold = 1'b0;
	end

	always @(negedge clk) begin
		// drop an item the block took at the last rising edge
		if (in_taken) begin
			expected_tilts.push_back(predict_tilt(pending_samples.pop_front()));
		end
		if (!arst_n || send_hold || pending_samples.size() == 0
				|| (send_idle_en && $urandom_range(99) < 25)) begin
			in_ch.valid <= 1'b0;
		end else begin
			in_ch.valid <= 1'b1;
			in_ch.quat_x <= pending_samples[0].qx;
			in_ch.quat_y <= pending_samples[0].qy;
			in_ch.quat_z <= pending_samples[0].qz;
			in_ch.quat_w <= pending_samples[0].qw;
			in_ch.rate_about_x <= pending_samples[0].wx;
			in_ch.rate_about_y <= pending_samples[0].wy;
		end
		// receiver side
		if (recv_hold) begin
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= arst_n && !(recv_idle_en && $urandom_range(99) < 25);
		end
	end

	// --- monitor: samples the result channel on the rising edge ---
	always @(posedge clk) begin
		tilt_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.frame_roll = out_ch.frame_roll;
			got.frame_pitch = out_ch.frame_pitch;
			got.control_roll = out_ch.control_roll;
			got.control_pitch = out_ch.control_pitch;
			got.roll_rate = out_ch.roll_rate;
			got.pitch_rate = out_ch.pitch_rate;
			// the expectation is pushed on the falling edge after acceptance,
			// well before any result can emerge from the pipeline
			if (expected_tilts.size() == 0) begin
				$error("result with nothing expected: roll %0d pitch %0d",
					got.frame_roll, got.frame_pitch);
				errors++;
			end else begin
				want = expected_tilts.pop_front();
				if (got.frame_roll !== want.frame_roll) begin
					$error("frame_roll exp %0d got %0d", want.frame_roll,
						got.frame_roll);
					errors++;
				end
				if (got.frame_pitch !== want.frame_pitch) begin
					$error("frame_pitch exp %0d got %0d", want.frame_pitch,
						got.frame_pitch);
					errors++;
				end
				if (got.control_roll !== want.control_roll) begin
					$error("control_roll exp %0d got %0d", want.control_roll,
						got.control_roll);
					errors++;
				end
				if (got.control_pitch !== want.control_pitch) begin
					$error("control_pitch exp %0d got %0d", want.control_pitch,
						got.control_pitch);
					errors++;
				end
				if (got.roll_rate !== want.roll_rate) begin
					$error("roll_rate exp %0d got %0d", want.roll_rate, got.roll_rate);
					errors++;
				end
				if (got.pitch_rate !== want.pitch_rate) begin
					$error("pitch_rate exp %0d got %0d", want.pitch_rate,
						got.pitch_rate);
					errors++;
				end
			end
		end
	end

	function automatic sample_t make_sample(int qx, int qy, int qz, int qw);
		sample_t s;
		s.qx = qx[15:0];
		s.qy = qy[15:0];
		s.qz = qz[15:0];
		s.qw = qw[15:0];
		s.wx = 16'($urandom());
		s.wy = 16'($urandom());
		return s;
	endfunction

	// a near-unit quaternion from random angles, with a little noise
	function automatic sample_t unit_sample();
		real a, b, c, n, v[4];
		int k[4];
		a = ($urandom_range(62831) / 10000.0);
		b = ($urandom_range(31415) / 10000.0);
		c = ($urandom_range(62831) / 10000.0);
		v[0] = $sin(b) * $cos(c) * $sin(a / 2.0 + 0.3);
		v[1] = $sin(b) * $sin(c) * $sin(a / 2.0 + 0.3);
		v[2] = $cos(b) * $sin(a / 2.0 + 0.3);
		v[3] = $cos(a / 2.0 + 0.3);
		n = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2] + v[3] * v[3]);
		for (int i = 0; i < 4; i++) begin
			k[i] = $rtoi(v[i] / n * 32767.0) + $urandom_range(8) - 4;
			if ($urandom_range(1)) k[i] = -k[i];
		end
		return make_sample(k[0], k[1], k[2], k[3]);
	endfunction

	task automatic wait_drained();
		while (pending_samples.size() != 0 || expected_tilts.size() != 0)
			@(posedge clk);
	endtask

	// --- stimulus ---
	initial begin
		sample_t s;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: identity, extremes, zero vector, atan2 on the negative
		// x axis, positive pitch saturation, largest and smallest rates
		pending_samples.push_back(make_sample(0, 0, 0, 32767));
		pending_samples.push_back(make_sample(0, 0, 0, 0));
		pending_samples.push_back(make_sample(32767, 0, 0, 0));
		pending_samples.push_back(make_sample(-32768, 0, 0, 0));
		pending_samples.push_back(make_sample(0, 32767, 0, 0));
		pending_samples.push_back(make_sample(0, 23170, 0, 23170));
		pending_samples.push_back(make_sample(0, -23170, 0, 23170));
		pending_samples.push_back(make_sample(0, 23171, 0, 23171));
		pending_samples.push_back(make_sample(23170, 0, 23170, 0));
		pending_samples.push_back(make_sample(-23170, 0, 23170, 0));
		pending_samples.push_back(make_sample(-32768, -32768, -32768, -32768));
		pending_samples.push_back(make_sample(32767, 32767, 32767, 32767));
		pending_samples.push_back(make_sample(-32768, 32767, -32768, 32767));
		pending_samples.push_back(make_sample(32767, -32768, 32767, -32768));
		pending_samples.push_back(make_sample(1, 0, 0, 1));
		pending_samples.push_back(make_sample(-1, -1, -1, -1));
		s = make_sample(0, 0, 0, 32767);
		s.wx = 16'sh7fff;
		s.wy = 16'sh8000;
		pending_samples.push_back(s);
		s.wx = 16'sh8000;
		s.wy = 16'sh7fff;
		pending_samples.push_back(s);
		// directed part runs back to back with no idling
		wait_drained();

		// random part: mostly near-unit quaternions, some raw bit patterns
		send_idle_en = 1'b1;
		recv_idle_en = 1'b1;
		for (int n = 0; n < 1500; n++) begin
			if ($urandom_range(99) < 75) s = unit_sample();
			else s = make_sample($urandom(), $urandom(), $urandom(), $urandom());
			pending_samples.push_back(s);
			if (n == 300) begin
				// receiver holds off long enough to fill the pipeline
				recv_hold_go = 1'b1;
			end
			if (n == 600 || n == 1100) begin
				// sender pauses until every result is back
				wait_drained();
			end
			if (n == 800) begin
				// a stretch with no idling on either side
				wait_drained();
				send_idle_en = 1'b0;
				recv_idle_en = 1'b0;
			end
			if (n == 1000) begin
				send_idle_en = 1'b1;
				recv_idle_en = 1'b1;
			end
			while (pending_samples.size() > 8) @(posedge clk);
		end
		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// timeout: far beyond the slowest correct run
	initial begin
		#400000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
